// ===== rtl/hfa_pkg.sv =====
// Package for the hole fitting allocator.
// Holds the address width, operation codes, status codes and sequencer state type; no dependencies.
package hfa_pkg;

  // Address width of the managed memory.
  localparam int AddrBits = 16;

  // Operation codes of an input item.
  localparam logic [1:0] FuncFirst = 2'd0;
  localparam logic [1:0] FuncBest  = 2'd1;
  localparam logic [1:0] FuncFree  = 2'd2;
  localparam logic [1:0] FuncDefrag = 2'd3;

  // Status codes of a result item.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StExceeds  = 3'd1;
  localparam logic [2:0] StDup      = 3'd2;
  localparam logic [2:0] StNoHole   = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StFull     = 3'd5;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_HOLE  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_PACK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

endpackage

// ===== rtl/hole_fitting_allocator_top.sv =====
// Top level of the hole fitting allocator: block table, sequencer and shared compare unit.
// Depends on hfa_pkg.
//
//  channel | direction | signals
//  in      | input     | in_valid_i, in_ready_o, func_i, block_ident_i, block_length_i
//  out     | output    | out_valid_o, out_ready_i, status_o, placed_address_o, space_left_o
//  cfg     | input     | cfg_we_i, cfg_wdata_i
//
// An allocate makes one pass over the table for the id check, one pass over the holes, then a
// one-entry-per-cycle shift of the table to open a slot; a free scans for the id and then shifts
// the table to close its slot, and a defragment makes one packing pass over the table.
// Reset clears the block count, the used total and the memory size; table contents stay undefined.
// A finished result is held in the output register until taken; the next item is
// accepted while that result waits, but work on it starts only once the result leaves.
module hole_fitting_allocator_top #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] block_ident_i,
  input  logic [15:0] block_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] placed_address_o,
  output logic [15:0] space_left_o
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = hfa_pkg::AddrBits + 1;

  // Block table.
  logic [15:0]   ident_mem [MAX_BLOCKS];
  logic [AW-1:0] begin_mem [MAX_BLOCKS];
  logic [AW-1:0] fin_mem   [MAX_BLOCKS];

  hfa_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q;
  logic [AW:0]   used_q;
  logic [15:0]   msize_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] pick_q;
  logic          found_q;
  logic [AW-1:0] pstart_q, psize_q, prev_fin_q, at_q;
  logic [1:0]    func_q;
  logic [15:0]   ident_q;
  logic [15:0]   len_q;
  logic          hold_q;
  logic          ovalid_q;
  logic [2:0]    status_q;
  logic [15:0]   placed_q;

  logic [AW:0]   remain;
  logic [IW-1:0] ridx;
  logic [15:0]   r_ident;
  logic [AW-1:0] r_begin, r_fin;
  logic [AW-1:0] gap_end, gap_len;
  logic          hole_ok;

  assign remain = (used_q > {{(AW-15){1'b0}}, msize_q}) ? '0 :
                  {{(AW-15){1'b0}}, msize_q} - used_q;
  assign ridx   = idx_q[IW-1:0];
  assign r_ident = ident_mem[ridx];
  assign r_begin = begin_mem[ridx];
  assign r_fin   = fin_mem[ridx];

  // Shared hole compare: end of hole is next block's start or memory size.
  assign gap_end = (idx_q < count_q) ? r_begin : {{(AW-16){1'b0}}, msize_q};
  assign gap_len = gap_end - prev_fin_q;
  assign hole_ok = (gap_end >= prev_fin_q) &&
                   (gap_len >= {{(AW-16){1'b0}}, len_q});

  assign in_ready_o  = !hold_q;
  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;
  assign placed_address_o = placed_q;
  assign space_left_o = remain[15:0];

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hfa_pkg::S_IDLE: if (hold_q && !ovalid_q) begin
        state_d = (func_q == hfa_pkg::FuncDefrag) ? hfa_pkg::S_PACK : hfa_pkg::S_SCAN;
      end
      hfa_pkg::S_SCAN: begin
        if (func_q == hfa_pkg::FuncFree) begin
          if (idx_q >= count_q) state_d = hfa_pkg::S_OUT;
          else if (r_ident == ident_q) state_d = hfa_pkg::S_SHIFT;
        end else if (status_q == hfa_pkg::StExceeds) begin
          state_d = hfa_pkg::S_OUT;
        end else if (idx_q >= count_q) begin
          state_d = (count_q >= CW'(MAX_BLOCKS)) ? hfa_pkg::S_OUT : hfa_pkg::S_HOLE;
        end else if (r_ident == ident_q) begin
          state_d = hfa_pkg::S_OUT;
        end
      end
      hfa_pkg::S_HOLE: begin
        if (hole_ok && func_q == hfa_pkg::FuncFirst) state_d = hfa_pkg::S_SHIFT;
        else if (idx_q >= count_q)
          state_d = (found_q || hole_ok) ? hfa_pkg::S_SHIFT : hfa_pkg::S_OUT;
      end
      hfa_pkg::S_SHIFT: begin
        if (func_q == hfa_pkg::FuncFree) begin
          if (idx_q + 1'b1 >= count_q) state_d = hfa_pkg::S_OUT;
        end else if (idx_q <= pick_q) begin
          state_d = hfa_pkg::S_WRITE;
        end
      end
      hfa_pkg::S_WRITE: state_d = hfa_pkg::S_OUT;
      hfa_pkg::S_PACK:  if (idx_q >= count_q) state_d = hfa_pkg::S_OUT;
      hfa_pkg::S_OUT:   state_d = hfa_pkg::S_IDLE;
      default:          state_d = hfa_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hfa_pkg::S_IDLE;
      count_q  <= '0;
      used_q   <= '0;
      msize_q  <= '0;
      hold_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) msize_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_o) hold_q <= 1'b1;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == hfa_pkg::S_OUT) begin
        ovalid_q <= 1'b1;
        hold_q   <= 1'b0;
      end
      if (state_q == hfa_pkg::S_WRITE) begin
        count_q <= count_q + 1'b1;
        used_q  <= used_q + {{(AW-15){1'b0}}, len_q};
      end
      if (state_q == hfa_pkg::S_SCAN && func_q == hfa_pkg::FuncFree &&
          idx_q < count_q && r_ident == ident_q) begin
        used_q <= ({1'b0, r_fin - r_begin} > used_q) ? '0 : used_q - {1'b0, r_fin - r_begin};
      end
      if (state_q == hfa_pkg::S_SHIFT && func_q == hfa_pkg::FuncFree &&
          idx_q + 1'b1 >= count_q) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Datapath registers and table writes.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q  <= func_i;
      ident_q <= block_ident_i;
      len_q   <= block_length_i;
    end
    unique case (state_q)
      hfa_pkg::S_IDLE: begin
        // A new item starts only after the previous result has left.
        if (hold_q && !ovalid_q) begin
          found_q <= 1'b0;
          prev_fin_q <= '0;
          at_q <= '0;
          placed_q <= '0;
          if (func_q != hfa_pkg::FuncDefrag && func_q != hfa_pkg::FuncFree &&
              {{(AW-15){1'b0}}, len_q} > remain) begin
            status_q <= hfa_pkg::StExceeds;
            idx_q <= CW'(MAX_BLOCKS);
          end else begin
            status_q <= hfa_pkg::StOk;
            idx_q <= '0;
          end
        end
      end
      hfa_pkg::S_SCAN: begin
        if (func_q == hfa_pkg::FuncFree) begin
          if (idx_q >= count_q) status_q <= hfa_pkg::StNotFound;
          else if (r_ident != ident_q) idx_q <= idx_q + 1'b1;
        end else if (status_q == hfa_pkg::StExceeds) begin
          idx_q <= idx_q;
        end else if (idx_q >= count_q) begin
          if (count_q >= CW'(MAX_BLOCKS)) status_q <= hfa_pkg::StFull;
          idx_q <= '0;
        end else if (r_ident == ident_q) begin
          status_q <= hfa_pkg::StDup;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      hfa_pkg::S_HOLE: begin
        if (hole_ok && (!found_q || (func_q == hfa_pkg::FuncBest && gap_len < psize_q))) begin
          found_q <= 1'b1;
          pick_q <= idx_q;
          pstart_q <= prev_fin_q;
          psize_q <= gap_len;
        end
        prev_fin_q <= r_fin;
        if ((hole_ok && func_q == hfa_pkg::FuncFirst) || idx_q >= count_q) begin
          idx_q <= count_q;
          if (!(found_q || hole_ok)) status_q <= hfa_pkg::StNoHole;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      hfa_pkg::S_SHIFT: begin
        if (func_q == hfa_pkg::FuncFree) begin
          if (idx_q + 1'b1 < count_q) begin
            ident_mem[ridx] <= ident_mem[IW'(idx_q + 1'b1)];
            begin_mem[ridx] <= begin_mem[IW'(idx_q + 1'b1)];
            fin_mem[ridx]   <= fin_mem[IW'(idx_q + 1'b1)];
            idx_q <= idx_q + 1'b1;
          end
        end else if (idx_q > pick_q) begin
          ident_mem[ridx] <= ident_mem[IW'(idx_q - 1'b1)];
          begin_mem[ridx] <= begin_mem[IW'(idx_q - 1'b1)];
          fin_mem[ridx]   <= fin_mem[IW'(idx_q - 1'b1)];
          idx_q <= idx_q - 1'b1;
        end
      end
      hfa_pkg::S_WRITE: begin
        ident_mem[IW'(pick_q)] <= ident_q;
        begin_mem[IW'(pick_q)] <= pstart_q;
        fin_mem[IW'(pick_q)]   <= pstart_q + {{(AW-16){1'b0}}, len_q};
        placed_q <= pstart_q[15:0];
      end
      hfa_pkg::S_PACK: begin
        if (idx_q < count_q) begin
          begin_mem[ridx] <= at_q;
          fin_mem[ridx]   <= at_q + (r_fin - r_begin);
          at_q <= at_q + (r_fin - r_begin);
          idx_q <= idx_q + 1'b1;
        end
      end
      hfa_pkg::S_OUT: idx_q <= '0;
      default: idx_q <= '0;
    endcase
  end

  // Checks on the sequencer and table bookkeeping.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(MAX_BLOCKS))
    else $error("block count beyond table depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hfa_pkg::S_OUT |=> out_valid_o)
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != hfa_pkg::S_IDLE |-> !in_ready_o)
    else $error("input taken while busy");

endmodule
